FILE: rtl/core/mxdp_pkg.sv
// Package for the MXFP4 block dot product: payload structs, format constants
// and the E2M1 decode function. No dependencies.
`default_nettype none

package mxdp_pkg;

   localparam int BLOCK_SIZE_DEF = 32;
   localparam int ACC_W          = 64;
   localparam int BPR_W          = 11;
   localparam int SCALE_W        = 8;
   localparam int X_W            = 16;
   localparam int CODE_W         = 4;
   localparam int WVAL_W         = 5;
   localparam int ACC_FRAC_SHIFT = 112;
   localparam int MAX_BLOCKS     = 1024;
   localparam int MAX_HALVES     = 12;
   localparam logic [BPR_W-1:0] BPR_RESET = BPR_W'(128);

   typedef struct packed {
      logic [7:0]                weight_pair;
      logic signed [X_W-1:0]     x_even;
      logic signed [X_W-1:0]     x_odd;
      logic [SCALE_W-1:0]        block_scale;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]   row_sum;
      logic                      saturated;
   } rsp_type;

   // E2M1 code to signed count of halves; negative zero decodes to zero
   function automatic logic signed [WVAL_W-1:0] decode_e2m1(input logic [CODE_W-1:0] code);
      logic [WVAL_W-1:0] mag;
      case (code[2:0])
         3'd0: mag = WVAL_W'(0);
         3'd1: mag = WVAL_W'(1);
         3'd2: mag = WVAL_W'(2);
         3'd3: mag = WVAL_W'(3);
         3'd4: mag = WVAL_W'(4);
         3'd5: mag = WVAL_W'(6);
         3'd6: mag = WVAL_W'(8);
         3'd7: mag = WVAL_W'(12);
         default: mag = WVAL_W'(0);
      endcase
      return code[3] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mxfp4_block_dot_product.sv
// Top level of the MXFP4 block dot product: block accumulation, scaling and
// saturating row accumulation. Depends on mxdp_pkg.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+----------------------------------
//   req     | in  | req_valid/req_stall  | mxdp_pkg::req_type
//   rsp     | out | rsp_valid/rsp_stall  | mxdp_pkg::rsp_type
//   csr     | in  | csr_valid/csr_ready  | blocks_per_row, 11 bits
//
// One transaction per cycle while req_stall is low. The block sum is built in
// the first stage; at a block end the scaled sum is added to the row
// accumulator in the second stage, and a row result is loaded from there into
// the output register once the output is not stalled with an earlier result.
// Synchronous reset clears control state but sets blocks_per_row to 128.
// req_stall rises only when a row result is waiting on a stalled output and
// the next block end would need the accumulator stage.
`default_nettype none

module mxfp4_block_dot_product #(
   parameter int BLOCK_SIZE = mxdp_pkg::BLOCK_SIZE_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  mxdp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output mxdp_pkg::rsp_type             rsp_data,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [mxdp_pkg::BPR_W-1:0]     csr_data
);
   import mxdp_pkg::*;

   localparam int ITEMS  = BLOCK_SIZE / 2;
   localparam int PC_W   = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int PART_W = $clog2(MAX_HALVES * (1 << (X_W - 1)) * 2 * ITEMS) + 1;
   localparam int PROD_W = WVAL_W + X_W;
   localparam int WIDE_W = PART_W + ACC_W - 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS);

   logic [BPR_W-1:0]         bpr_ff;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   logic signed [PART_W-1:0] part_ff, part_in;
   logic                     blk_valid_ff, blk_valid_in;
   logic signed [PART_W-1:0] blk_sum_ff, blk_sum_in;
   logic [SCALE_W-1:0]       blk_scale_ff, blk_scale_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     req_take, pair_last, b_stall, row_end;
   logic [SCALE_W-1:0]       scale_use;
   logic signed [PROD_W-1:0] prod_even, prod_odd;
   logic signed [PART_W-1:0] part_sum;
   logic signed [9:0]        shift_s;
   logic [9:0]               rsh;
   logic [5:0]               rsh_clip;
   logic signed [WIDE_W-1:0] wide;
   logic signed [ACC_W-1:0]  term;
   logic                     term_ov, add_ov;
   logic signed [ACC_W:0]    sum_ext;
   logic signed [ACC_W-1:0]  acc_new;
   logic [CNT_W:0]           cnt_next;
   logic [BPR_W-1:0]         rows;

   // Stage 1: block partial sum
   always_comb begin
      pair_last = (pc_ff == PC_W'(ITEMS - 1));
      req_stall = b_stall && pair_last;
      req_take  = req_valid && !req_stall;
      scale_use = (pc_ff == '0) ? req_data.block_scale : scale_ff;
      prod_even = decode_e2m1(req_data.weight_pair[3:0]) * req_data.x_even;
      prod_odd  = decode_e2m1(req_data.weight_pair[7:4]) * req_data.x_odd;
      part_sum  = part_ff + PART_W'(prod_even) + PART_W'(prod_odd);
      pc_in        = pc_ff;
      part_in      = part_ff;
      scale_in     = scale_ff;
      blk_valid_in = blk_valid_ff && b_stall;
      blk_sum_in   = blk_sum_ff;
      blk_scale_in = blk_scale_ff;
      if (req_take) begin
         scale_in = scale_use;
         if (pair_last) begin
            pc_in        = '0;
            part_in      = '0;
            blk_valid_in = 1'b1;
            blk_sum_in   = part_sum;
            blk_scale_in = scale_use;
         end else begin
            pc_in   = pc_ff + PC_W'(1);
            part_in = part_sum;
         end
      end
   end

   // Stage 2: scale and saturating row accumulation
   always_comb begin
      shift_s  = $signed({2'b00, blk_scale_ff}) - 10'sd112;
      rsh      = -shift_s;
      rsh_clip = (rsh >= 10'd63) ? 6'd63 : rsh[5:0];
      wide     = WIDE_W'(blk_sum_ff) <<< shift_s[5:0];
      term_ov  = 1'b0;
      if (shift_s >= 10'sd0) begin
         if (blk_sum_ff == '0) begin
            term = '0;
         end else if (shift_s >= 10'sd63) begin
            term_ov = 1'b1;
            term    = '0;
         end else begin
            term_ov = !((&wide[WIDE_W-1:ACC_W-1]) || !(|wide[WIDE_W-1:ACC_W-1]));
            term    = wide[ACC_W-1:0];
         end
      end else begin
         term = ACC_W'(blk_sum_ff) >>> rsh_clip;
      end
      sum_ext = {acc_ff[ACC_W-1], acc_ff} + {term[ACC_W-1], term};
      add_ov  = sum_ext[ACC_W] != sum_ext[ACC_W-1];
      if (term_ov || add_ov) begin
         acc_new = blk_sum_ff[PART_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_new = sum_ext[ACC_W-1:0];
      end
      cnt_next = {1'b0, cnt_ff} + (CNT_W+1)'(1);
      if (bpr_ff == '0) begin
         rows = BPR_W'(1);
      end else if (bpr_ff > BPR_W'(MAX_BLOCKS)) begin
         rows = BPR_W'(MAX_BLOCKS);
      end else begin
         rows = bpr_ff;
      end
      row_end = (BPR_W'(cnt_next) >= rows);
      b_stall = blk_valid_ff && row_end && rsp_valid_ff && rsp_stall;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (blk_valid_ff && !b_stall) begin
         if (row_end) begin
            cnt_in            = '0;
            acc_in            = '0;
            ovf_in            = 1'b0;
            rsp_valid_in      = 1'b1;
            rsp_in.row_sum    = acc_new;
            rsp_in.saturated  = ovf_ff || term_ov || add_ov;
         end else begin
            cnt_in = cnt_next[CNT_W-1:0];
            acc_in = acc_new;
            ovf_in = ovf_ff || term_ov || add_ov;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff       <= BPR_RESET;
         pc_ff        <= '0;
         part_ff      <= '0;
         scale_ff     <= SCALE_W'(127);
         blk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            bpr_ff <= csr_data;
         end
         pc_ff        <= pc_in;
         part_ff      <= part_in;
         scale_ff     <= scale_in;
         blk_valid_ff <= blk_valid_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_sum_ff   <= blk_sum_in;
      blk_scale_ff <= blk_scale_in;
      rsp_ff       <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && blk_valid_ff))
      else $error("input stalled without a blocked result");

   a_block_handoff: assert property (@(posedge clock) disable iff (reset)
      (req_take && pair_last) |=> (blk_valid_ff && pc_ff == '0 && part_ff == '0))
      else $error("block end not handed to accumulator stage");

   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      (blk_valid_ff && !b_stall && row_end) |=> (rsp_valid_ff && acc_ff == '0 && !ovf_ff))
      else $error("row end did not clear accumulator");

   a_partial_idle: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == '0) |-> (part_ff == '0))
      else $error("partial sum not cleared at block start");

endmodule

`default_nettype wire
